/* hw/rtl/hdlp_pkg.sv */
// Shared types, register indexes and reset values for the hysteresis
// debouncer with long-press detection. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdlp_pkg;

    localparam int COUNT_WIDTH_DEF = 8;
    localparam int LONG_WIDTH_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_MAX  = 3'd0,
        REG_THR_HIGH   = 3'd1,
        REG_THR_LOW    = 3'd2,
        REG_LONG_COUNT = 3'd3,
        REG_START_HIGH = 3'd4
    } t_reg_idx;

    localparam logic [7:0]  COUNT_MAX_RST  = 8'd10;
    localparam logic [7:0]  THR_HIGH_RST   = 8'd8;
    localparam logic [7:0]  THR_LOW_RST    = 8'd2;
    localparam logic [15:0] LONG_COUNT_RST = 16'd0;

    typedef struct packed {
        logic [7:0]  count_max;
        logic [7:0]  thr_high;
        logic [7:0]  thr_low;
        logic [15:0] long_count;
    } t_cfg;

    typedef struct packed {
        logic reinit;
        logic start_high;
    } t_init;

    typedef struct packed {
        logic sample_is_high;
        logic ack_rising;
        logic ack_falling;
        logic ack_long_high;
        logic ack_long_low;
    } t_item;

    typedef struct packed {
        logic debounced_high;
        logic rising_seen;
        logic falling_seen;
        logic long_high_seen;
        logic long_low_seen;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/hdlp_cfg.sv */
// Configuration register file of the debouncer.
// Depends on hdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdlp_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hdlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hdlp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hdlp_pkg::t_cfg                      o_cfg,
    output hdlp_pkg::t_init                     o_init
);

    hdlp_pkg::t_cfg   r_cfg;
    hdlp_pkg::t_reg_idx w_idx;

    assign w_idx = hdlp_pkg::t_reg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_max  <= hdlp_pkg::COUNT_MAX_RST;
            r_cfg.thr_high   <= hdlp_pkg::THR_HIGH_RST;
            r_cfg.thr_low    <= hdlp_pkg::THR_LOW_RST;
            r_cfg.long_count <= hdlp_pkg::LONG_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (w_idx)
                hdlp_pkg::REG_COUNT_MAX:  r_cfg.count_max  <= i_cfg_data[7:0];
                hdlp_pkg::REG_THR_HIGH:   r_cfg.thr_high   <= i_cfg_data[7:0];
                hdlp_pkg::REG_THR_LOW:    r_cfg.thr_low    <= i_cfg_data[7:0];
                hdlp_pkg::REG_LONG_COUNT: r_cfg.long_count <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // start_high is only used at the moment of its write
    assign o_init.reinit     = i_cfg_we && (w_idx == hdlp_pkg::REG_START_HIGH);
    assign o_init.start_high = i_cfg_data[0];
    assign o_cfg             = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/hdlp_core.sv */
// Integrator, hysteresis compare, long-press countdown and sticky flags.
// Depends on hdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdlp_core #(
    parameter int COUNT_WIDTH = hdlp_pkg::COUNT_WIDTH_DEF,
    parameter int LONG_WIDTH  = hdlp_pkg::LONG_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hdlp_pkg::t_cfg  i_cfg,
    input  wire hdlp_pkg::t_init i_init,
    input  wire logic          i_step,
    input  wire hdlp_pkg::t_item i_item,
    output hdlp_pkg::t_result  o_result,
    output hdlp_pkg::t_result  o_state
);

    localparam logic [16:0] CNT_MAX17 = (17'd1 << COUNT_WIDTH) - 17'd1;
    localparam logic [32:0] TMR_MAX33 = (33'd1 << LONG_WIDTH) - 33'd1;

    logic                   r_level;
    logic [COUNT_WIDTH-1:0] r_integ;
    logic [LONG_WIDTH-1:0]  r_timer;
    logic                   r_rise;
    logic                   r_fall;
    logic                   r_lhi;
    logic                   r_llo;

    logic [16:0]            w_cm17;
    logic [32:0]            w_lc33;
    logic [COUNT_WIDTH-1:0] w_limit;
    logic [LONG_WIDTH-1:0]  w_reload;

    logic                   n_level;
    logic [COUNT_WIDTH-1:0] n_integ;
    logic [LONG_WIDTH-1:0]  n_timer;
    logic                   w_rise;
    logic                   w_fall;
    logic                   w_lhi;
    logic                   w_llo;

    assign w_cm17   = 17'(i_cfg.count_max);
    assign w_lc33   = 33'(i_cfg.long_count);
    assign w_limit  = (w_cm17 > CNT_MAX17) ? CNT_MAX17[COUNT_WIDTH-1:0]
                                           : w_cm17[COUNT_WIDTH-1:0];
    assign w_reload = (w_lc33 > TMR_MAX33) ? TMR_MAX33[LONG_WIDTH-1:0]
                                           : w_lc33[LONG_WIDTH-1:0];

    always_comb begin
        n_integ = r_integ;
        n_level = r_level;
        n_timer = r_timer;
        w_rise  = r_rise;
        w_fall  = r_fall;
        w_lhi   = r_lhi;
        w_llo   = r_llo;

        if (i_item.sample_is_high) begin
            if (r_integ < w_limit) begin
                n_integ = r_integ + COUNT_WIDTH'(1);
            end
            if ((17'(n_integ) == 17'(i_cfg.thr_high)) && !r_level) begin
                n_level = 1'b1;
                w_rise  = 1'b1;
                n_timer = w_reload;
            end
        end else begin
            if (r_integ != '0) begin
                n_integ = r_integ - COUNT_WIDTH'(1);
            end
            if ((17'(n_integ) == 17'(i_cfg.thr_low)) && r_level) begin
                n_level = 1'b0;
                w_fall  = 1'b1;
                n_timer = w_reload;
            end
        end

        if (n_timer != '0) begin
            n_timer = n_timer - LONG_WIDTH'(1);
            if (n_timer == '0) begin
                if (n_level) begin
                    w_lhi = 1'b1;
                end else begin
                    w_llo = 1'b1;
                end
            end
        end
    end

    assign o_result.debounced_high = n_level;
    assign o_result.rising_seen    = w_rise;
    assign o_result.falling_seen   = w_fall;
    assign o_result.long_high_seen = w_lhi;
    assign o_result.long_low_seen  = w_llo;

    assign o_state.debounced_high = r_level;
    assign o_state.rising_seen    = r_rise;
    assign o_state.falling_seen   = r_fall;
    assign o_state.long_high_seen = r_lhi;
    assign o_state.long_low_seen  = r_llo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_integ <= '0;
            r_timer <= '0;
            r_rise  <= 1'b0;
            r_fall  <= 1'b0;
            r_lhi   <= 1'b0;
            r_llo   <= 1'b0;
        end else if (i_init.reinit) begin
            r_level <= i_init.start_high;
            r_integ <= i_init.start_high ? w_limit : '0;
            r_timer <= '0;
            r_rise  <= 1'b0;
            r_fall  <= 1'b0;
            r_lhi   <= 1'b0;
            r_llo   <= 1'b0;
        end else if (i_step) begin
            r_level <= n_level;
            r_integ <= n_integ;
            r_timer <= n_timer;
            r_rise  <= w_rise && !i_item.ack_rising;
            r_fall  <= w_fall && !i_item.ack_falling;
            r_lhi   <= w_lhi  && !i_item.ack_long_high;
            r_llo   <= w_llo  && !i_item.ack_long_low;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hysteresis_debouncer_long_press_top.sv */
// Top level of the hysteresis debouncer with long-press detection.
// Depends on hdlp_pkg, hdlp_cfg and hdlp_core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one sampled level word per clock while input ready is high. Each
// accepted word updates the integrator, the debounced state, the long-press
// countdown and the sticky flags in the cycle it is accepted; its result word
// appears from the output register on the next cycle. Input ready is high
// whenever the output register is empty or being drained, so a steady stream
// runs at one word per cycle. Flags are reported before that word's
// acknowledge bits clear them. Writing start_high re-initializes the state,
// integrator, countdown and flags; other registers take effect at once.

module hysteresis_debouncer_long_press_top #(
    parameter int COUNT_WIDTH = hdlp_pkg::COUNT_WIDTH_DEF,
    parameter int LONG_WIDTH  = hdlp_pkg::LONG_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [0] sample_is_high [1] ack_rising [2] ack_falling
    // [3] ack_long_high [4] ack_long_low [7:5] zero
    input  wire logic [7:0]                      i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [0] debounced_high [1] rising_seen [2] falling_seen
    // [3] long_high_seen [4] long_low_seen [7:5] zero
    output logic [7:0]                           o_m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [hdlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hdlp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    hdlp_pkg::t_cfg    w_cfg;
    hdlp_pkg::t_init   w_init;
    hdlp_pkg::t_item   w_item;
    hdlp_pkg::t_result w_res;
    hdlp_pkg::t_result w_state;
    logic              w_accept;

    logic              r_out_valid;
    hdlp_pkg::t_result r_out;

    assign w_item.sample_is_high = i_s_axis_tdata[0];
    assign w_item.ack_rising     = i_s_axis_tdata[1];
    assign w_item.ack_falling    = i_s_axis_tdata[2];
    assign w_item.ack_long_high  = i_s_axis_tdata[3];
    assign w_item.ack_long_low   = i_s_axis_tdata[4];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    hdlp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_init     (w_init)
    );

    hdlp_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .LONG_WIDTH  (LONG_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_init   (w_init),
        .i_step   (w_accept),
        .i_item   (w_item),
        .o_result (w_res),
        .o_state  (w_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.long_low_seen, r_out.long_high_seen,
                              r_out.falling_seen, r_out.rising_seen,
                              r_out.debounced_high};

`ifndef SYNTHESIS
    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_m_axis_tvalid)
        else $error("accepted word did not reach the output register");

    a_rise_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_state.debounced_high && w_res.debounced_high)
        |-> w_res.rising_seen)
        else $error("low to high change without rising flag");

    a_fall_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_state.debounced_high && !w_res.debounced_high)
        |-> w_res.falling_seen)
        else $error("high to low change without falling flag");

    a_reinit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init.reinit |=> (!w_state.rising_seen && !w_state.falling_seen &&
                           !w_state.long_high_seen && !w_state.long_low_seen))
        else $error("start_high write left flags set");
`endif

endmodule

`default_nettype wire
